>>> sv/ssd_pkg.sv
`timescale 1ns / 1ps

package ssd_pkg;

	// Field widths and fixed-point formats.
	localparam int COORD_WIDTH     = 16;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 8;
	localparam int OUT_WIDTH       = 41;
	localparam int EPS_WIDTH       = 16;

	// Derived widths.
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int DOT_W   = 2 * DIFF_W + 1;
	localparam int PX_W    = COORD_WIDTH + PARAM_FRAC_BITS + 3;
	localparam int MUL_RAW = (DOT_W > PX_W) ? DOT_W : PX_W;
	localparam int MUL_W   = MUL_RAW + (MUL_RAW % 2);
	localparam int HALF_W  = MUL_W / 2;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SQ_W    = PROD_W + 1;
	localparam int SQ_SHIFT = 2 * PARAM_FRAC_BITS - OUT_FRAC_BITS;

	// Latencies of the multiplier and divider units.
	localparam int MUL_LAT = 3;
	localparam int DIV_LAT = PARAM_FRAC_BITS;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [MUL_W-1:0]       mul_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic [PARAM_FRAC_BITS:0]      param_t;

	typedef struct packed {
		diff_t ux;
		diff_t uy;
		diff_t vx;
		diff_t vy;
		diff_t wx;
		diff_t wy;
	} geo_t;

	typedef struct packed {
		mul_t da;
		mul_t db;
		mul_t dc;
		mul_t dd;
		mul_t de;
	} dot_t;

	// How a clamped parameter is formed.
	typedef enum logic [1:0] {
		QM_ZERO,
		QM_ONE,
		QM_DIV
	} qmode_t;

endpackage

>>> sv/ssd_if.sv
`timescale 1ns / 1ps

interface ssd_pair_if;
	logic valid;
	logic ready;
	ssd_pkg::coord_t first_start_x;
	ssd_pkg::coord_t first_start_y;
	ssd_pkg::coord_t first_end_x;
	ssd_pkg::coord_t first_end_y;
	ssd_pkg::coord_t second_start_x;
	ssd_pkg::coord_t second_start_y;
	ssd_pkg::coord_t second_end_x;
	ssd_pkg::coord_t second_end_y;

	modport source(output valid, output first_start_x, output first_start_y,
		output first_end_x, output first_end_y, output second_start_x,
		output second_start_y, output second_end_x, output second_end_y, input ready);
	modport sink(input valid, input first_start_x, input first_start_y,
		input first_end_x, input first_end_y, input second_start_x,
		input second_start_y, input second_end_x, input second_end_y, output ready);
endinterface

interface ssd_dist_if;
	logic valid;
	logic ready;
	logic [ssd_pkg::OUT_WIDTH-1:0] squared_distance;

	modport source(output valid, output squared_distance, input ready);
	modport sink(input valid, input squared_distance, output ready);
endinterface

interface ssd_cfg_if;
	logic valid;
	logic ready;
	logic [ssd_pkg::EPS_WIDTH-1:0] epsilon;

	modport source(output valid, output epsilon, input ready);
	modport sink(input valid, input epsilon, output ready);
endinterface

>>> sv/ssd_mul.sv
`timescale 1ns / 1ps

// Three-stage signed multiplier built from four half-width partial products.
module ssd_mul (
	input  logic          clk,
	input  logic          en,
	input  ssd_pkg::mul_t a,
	input  ssd_pkg::mul_t b,
	output ssd_pkg::prod_t p
);
	localparam int H = ssd_pkg::HALF_W;

	logic signed [H-1:0]   a_hi, b_hi;
	logic signed [2*H-1:0] hh_c;
	logic signed [2*H:0]   hl_c, lh_c;
	logic [2*H-1:0]        ll_c;

	logic signed [2*H-1:0] hh_s1;
	logic signed [2*H:0]   hl_s1, lh_s1;
	logic [2*H-1:0]        ll_s1;

	logic signed [2*H+1:0] mid_s2;
	ssd_pkg::prod_t        hilo_s2;
	ssd_pkg::prod_t        mid_ext;
	ssd_pkg::prod_t        p_s3;

	assign a_hi = a[2*H-1:H];
	assign b_hi = b[2*H-1:H];
	assign hh_c = a_hi * b_hi;
	assign hl_c = a_hi * $signed({1'b0, b[H-1:0]});
	assign lh_c = $signed({1'b0, a[H-1:0]}) * b_hi;
	assign ll_c = a[H-1:0] * b[H-1:0];

	assign mid_ext = ssd_pkg::prod_t'(mid_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1   <= hh_c;
			hl_s1   <= hl_c;
			lh_s1   <= lh_c;
			ll_s1   <= ll_c;
			mid_s2  <= hl_s1 + lh_s1;
			hilo_s2 <= {hh_s1, ll_s1};
			p_s3    <= hilo_s2 + (mid_ext <<< H);
		end
	end

	assign p = p_s3;

endmodule

>>> sv/ssd_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage. For a real division
// the numerator is below the denominator, so the quotient is a pure fraction.
module ssd_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ssd_pkg::PROD_W-1:0]  num,
	input  logic [ssd_pkg::PROD_W-1:0]  den,
	input  ssd_pkg::qmode_t             mode,
	output ssd_pkg::param_t             q
);
	localparam int W = ssd_pkg::PROD_W;
	localparam int N = ssd_pkg::DIV_LAT;
	localparam int F = ssd_pkg::PARAM_FRAC_BITS;

	logic [W-1:0]     rem_s [N];
	logic [W-1:0]     den_s [N];
	logic [F-1:0]     qb_s  [N];
	ssd_pkg::qmode_t  mode_s[N];

	logic [W-1:0]     r_in  [N];
	logic [W-1:0]     d_in  [N];
	logic [F-1:0]     q_in  [N];
	ssd_pkg::qmode_t  m_in  [N];
	logic [W:0]       sh    [N];
	logic [W:0]       diff  [N];
	logic             ge    [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		if (k == 0) begin : g_first
			assign r_in[k] = num;
			assign d_in[k] = den;
			assign q_in[k] = '0;
			assign m_in[k] = mode;
		end else begin : g_next
			assign r_in[k] = rem_s[k-1];
			assign d_in[k] = den_s[k-1];
			assign q_in[k] = qb_s[k-1];
			assign m_in[k] = mode_s[k-1];
		end
		assign sh[k]   = {r_in[k], 1'b0};
		assign diff[k] = sh[k] - {1'b0, d_in[k]};
		assign ge[k]   = (sh[k] >= {1'b0, d_in[k]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= ge[k] ? diff[k][W-1:0] : sh[k][W-1:0];
				den_s[k]  <= d_in[k];
				qb_s[k]   <= {q_in[k][F-2:0], ge[k]};
				mode_s[k] <= m_in[k];
			end
		end
	end

	always_comb begin
		case (mode_s[N-1])
			ssd_pkg::QM_ONE: q = {1'b1, {F{1'b0}}};
			ssd_pkg::QM_DIV: q = {1'b0, qb_s[N-1]};
			default:         q = '0;
		endcase
	end

endmodule

>>> sv/segment_segment_sq_distance.sv
`timescale 1ns / 1ps

// Squared shortest distance between two 2D segments, P0-P1 and Q0-Q1.
// The pair channel takes one beat per segment pair, eight signed coordinates.
// The result channel returns one beat per pair: the squared distance, unsigned,
// with 8 fractional bits, truncated and saturated to the field width.
// The cfg channel writes the epsilon register; it is always ready and should
// only be written while no pair is in flight.
// From an accepted pair beat to its result beat the stages are, in order: the
// differences and dot products, the wide multipliers, clamping and parameter
// setup, the two dividers over the fractional bits, the closest-point
// difference, the multipliers again and the output register.
// Throughput is one pair per cycle unless the output stalls; the pipeline is fully occupied then.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and pair ready drops in the same cycle, so nothing is lost.
// Reset clears all valid bits and sets epsilon to 1.
module segment_segment_sq_distance (
	input logic         clk,
	input logic         arst_n,
	ssd_pair_if.sink    pair,
	ssd_dist_if.source  result,
	ssd_cfg_if.sink     cfg
);
	localparam int F      = ssd_pkg::PARAM_FRAC_BITS;
	localparam int ML     = ssd_pkg::MUL_LAT;
	localparam int GEO_DL = 7 + ssd_pkg::DIV_LAT;
	localparam int LAT    = 10 + ssd_pkg::DIV_LAT + ML + 1;
	localparam int PW     = ssd_pkg::PROD_W;

	// Handshake and global advance. Every stage moves only when the output
	// register is free or being emptied.
	logic                          adv;
	logic                          pair_fire;
	logic [LAT-1:0]                vld_q;
	logic [ssd_pkg::EPS_WIDTH-1:0] eps_q;
	ssd_pkg::prod_t                eps_w;

	assign adv        = !vld_q[LAT-1] || result.ready;
	assign pair.ready = adv;
	assign pair_fire  = pair.valid && adv;
	assign cfg.ready  = 1'b1;
	assign eps_w      = {{(PW-ssd_pkg::EPS_WIDTH){1'b0}}, eps_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			eps_q <= ssd_pkg::EPS_WIDTH'(1);
		end else begin
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], pair_fire};
			end
			if (cfg.valid) begin
				eps_q <= cfg.epsilon;
			end
		end
	end

	// Stage 1: edge vectors u = P1-P0, v = Q1-Q0 and offset w = P0-Q0.
	ssd_pkg::geo_t geo_c, geo_s1, geo_s2;
	ssd_pkg::geo_t geo_dl [GEO_DL];

	always_comb begin
		geo_c.ux = ssd_pkg::diff_t'(pair.first_end_x) - ssd_pkg::diff_t'(pair.first_start_x);
		geo_c.uy = ssd_pkg::diff_t'(pair.first_end_y) - ssd_pkg::diff_t'(pair.first_start_y);
		geo_c.vx = ssd_pkg::diff_t'(pair.second_end_x) - ssd_pkg::diff_t'(pair.second_start_x);
		geo_c.vy = ssd_pkg::diff_t'(pair.second_end_y) - ssd_pkg::diff_t'(pair.second_start_y);
		geo_c.wx = ssd_pkg::diff_t'(pair.first_start_x) - ssd_pkg::diff_t'(pair.second_start_x);
		geo_c.wy = ssd_pkg::diff_t'(pair.first_start_y) - ssd_pkg::diff_t'(pair.second_start_y);
	end

	// Stage 2: the five dot products.
	ssd_pkg::dot_t dot_c, dot_s2, dot_s6, dot_s7;
	ssd_pkg::dot_t dot_dl [ML];

	always_comb begin
		dot_c.da = geo_s1.ux * geo_s1.ux + geo_s1.uy * geo_s1.uy;
		dot_c.db = geo_s1.ux * geo_s1.vx + geo_s1.uy * geo_s1.vy;
		dot_c.dc = geo_s1.vx * geo_s1.vx + geo_s1.vy * geo_s1.vy;
		dot_c.dd = geo_s1.ux * geo_s1.wx + geo_s1.uy * geo_s1.wy;
		dot_c.de = geo_s1.vx * geo_s1.wx + geo_s1.vy * geo_s1.wy;
	end

	// Stages 3 to 5: the six cross products for the determinant and numerators.
	ssd_pkg::prod_t p_dadc, p_dbdb, p_dbde, p_dcdd, p_dade, p_dbdd;

	ssd_mul u_mul_dadc (.clk(clk), .en(adv), .a(dot_s2.da), .b(dot_s2.dc), .p(p_dadc));
	ssd_mul u_mul_dbdb (.clk(clk), .en(adv), .a(dot_s2.db), .b(dot_s2.db), .p(p_dbdb));
	ssd_mul u_mul_dbde (.clk(clk), .en(adv), .a(dot_s2.db), .b(dot_s2.de), .p(p_dbde));
	ssd_mul u_mul_dcdd (.clk(clk), .en(adv), .a(dot_s2.dc), .b(dot_s2.dd), .p(p_dcdd));
	ssd_mul u_mul_dade (.clk(clk), .en(adv), .a(dot_s2.da), .b(dot_s2.de), .p(p_dade));
	ssd_mul u_mul_dbdd (.clk(clk), .en(adv), .a(dot_s2.db), .b(dot_s2.dd), .p(p_dbdd));

	// Stage 6: determinant and the two unclamped numerators.
	ssd_pkg::prod_t det_s6, sn_s6, tn_s6;

	// Stage 7: nearly parallel test and clamping of s to the segment.
	ssd_pkg::prod_t de_w, db_w, dc_w;
	ssd_pkg::prod_t sn_c7, sd_c7, tn_c7, td_c7;
	ssd_pkg::prod_t sn_s7, sd_s7, tn_s7, td_s7;

	assign de_w = ssd_pkg::prod_t'(dot_s6.de);
	assign db_w = ssd_pkg::prod_t'(dot_s6.db);
	assign dc_w = ssd_pkg::prod_t'(dot_s6.dc);

	// When s is clamped to either end, t is taken over the second segment
	// alone, so its denominator stays dc.
	always_comb begin
		sn_c7 = '0;
		sd_c7 = ssd_pkg::prod_t'(1);
		tn_c7 = de_w;
		td_c7 = dc_w;
		if (!(det_s6 < eps_w)) begin
			sd_c7 = det_s6;
			if (sn_s6[PW-1]) begin
				sn_c7 = '0;
			end else if (det_s6 < sn_s6) begin
				sn_c7 = det_s6;
				tn_c7 = de_w + db_w;
			end else begin
				sn_c7 = sn_s6;
				tn_c7 = tn_s6;
				td_c7 = det_s6;
			end
		end
	end

	// Stage 8: clamping of t, which may pull s back onto its segment.
	ssd_pkg::prod_t dd_w, db7_w, da7_w, f_lo, f_hi, f_sel;
	ssd_pkg::prod_t sn_c8, sd_c8, tn_c8;
	ssd_pkg::prod_t sn_s8, sd_s8, tn_s8, td_s8;
	logic           reclamp;

	assign dd_w  = ssd_pkg::prod_t'(dot_s7.dd);
	assign db7_w = ssd_pkg::prod_t'(dot_s7.db);
	assign da7_w = ssd_pkg::prod_t'(dot_s7.da);
	assign f_lo  = -dd_w;
	assign f_hi  = db7_w - dd_w;

	always_comb begin
		sn_c8   = sn_s7;
		sd_c8   = sd_s7;
		tn_c8   = tn_s7;
		reclamp = 1'b0;
		f_sel   = f_lo;
		if (tn_s7[PW-1]) begin
			tn_c8   = '0;
			reclamp = 1'b1;
		end else if (td_s7 < tn_s7) begin
			tn_c8   = td_s7;
			reclamp = 1'b1;
			f_sel   = f_hi;
		end
		if (reclamp) begin
			if (f_sel[PW-1]) begin
				sn_c8 = '0;
			end else if (f_sel > da7_w) begin
				sn_c8 = sd_s7;
			end else begin
				sn_c8 = f_sel;
				sd_c8 = da7_w;
			end
		end
	end

	// Stage 9: pick zero, one or a true division for each parameter.
	function automatic ssd_pkg::qmode_t param_mode(ssd_pkg::prod_t num,
			ssd_pkg::prod_t den, ssd_pkg::prod_t eps);
		ssd_pkg::qmode_t m;
		if (num[PW-1] || num < eps || den[PW-1] || den == '0) begin
			m = ssd_pkg::QM_ZERO;
		end else if (num >= den) begin
			m = ssd_pkg::QM_ONE;
		end else begin
			m = ssd_pkg::QM_DIV;
		end
		return m;
	endfunction

	logic [PW-1:0]   sn_s9, sd_s9, tn_s9, td_s9;
	ssd_pkg::qmode_t smode_s9, tmode_s9;

	// Stages 10 to 25: the two parameter dividers.
	ssd_pkg::param_t sc, tc;

	ssd_div u_div_s (.clk(clk), .en(adv), .num(sn_s9), .den(sd_s9), .mode(smode_s9), .q(sc));
	ssd_div u_div_t (.clk(clk), .en(adv), .num(tn_s9), .den(td_s9), .mode(tmode_s9), .q(tc));

	// Stage 26: closest-point difference w + s*u - t*v in fixed point.
	ssd_pkg::geo_t               geo_d;
	logic signed [F+1:0]         sc_sg, tc_sg;
	logic signed [F+ssd_pkg::DIFF_W:0] su_x, su_y, tv_x, tv_y;
	ssd_pkg::mul_t               wx_e, wy_e, px_c, py_c, px_s26, py_s26;

	assign geo_d = geo_dl[GEO_DL-1];
	assign sc_sg = {1'b0, sc};
	assign tc_sg = {1'b0, tc};
	assign su_x  = sc_sg * geo_d.ux;
	assign su_y  = sc_sg * geo_d.uy;
	assign tv_x  = tc_sg * geo_d.vx;
	assign tv_y  = tc_sg * geo_d.vy;
	assign wx_e  = ssd_pkg::mul_t'(geo_d.wx);
	assign wy_e  = ssd_pkg::mul_t'(geo_d.wy);
	assign px_c  = (wx_e <<< F) + ssd_pkg::mul_t'(su_x) - ssd_pkg::mul_t'(tv_x);
	assign py_c  = (wy_e <<< F) + ssd_pkg::mul_t'(su_y) - ssd_pkg::mul_t'(tv_y);

	// Stages 27 to 29: squares of both components.
	ssd_pkg::prod_t pxx, pyy;

	ssd_mul u_mul_px (.clk(clk), .en(adv), .a(px_s26), .b(px_s26), .p(pxx));
	ssd_mul u_mul_py (.clk(clk), .en(adv), .a(py_s26), .b(py_s26), .p(pyy));

	// Stage 30: sum, drop the extra fraction bits and saturate.
	logic [ssd_pkg::SQ_W-1:0]      sq_c, sq_sh;
	logic [ssd_pkg::OUT_WIDTH-1:0] sqd_c, sqd_q;

	assign sq_c  = ssd_pkg::SQ_W'($unsigned(pxx)) + ssd_pkg::SQ_W'($unsigned(pyy));
	assign sq_sh = sq_c >> ssd_pkg::SQ_SHIFT;
	assign sqd_c = (|sq_sh[ssd_pkg::SQ_W-1:ssd_pkg::OUT_WIDTH]) ? '1
		: sq_sh[ssd_pkg::OUT_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= geo_c;
			geo_s2 <= geo_s1;
			geo_dl[0] <= geo_s2;
			for (int k = 1; k < GEO_DL; k++) begin
				geo_dl[k] <= geo_dl[k-1];
			end
			dot_s2 <= dot_c;
			dot_dl[0] <= dot_s2;
			for (int k = 1; k < ML; k++) begin
				dot_dl[k] <= dot_dl[k-1];
			end
			dot_s6 <= dot_dl[ML-1];
			dot_s7 <= dot_s6;
			det_s6 <= p_dadc - p_dbdb;
			sn_s6  <= p_dbde - p_dcdd;
			tn_s6  <= p_dade - p_dbdd;
			sn_s7  <= sn_c7;
			sd_s7  <= sd_c7;
			tn_s7  <= tn_c7;
			td_s7  <= td_c7;
			sn_s8  <= sn_c8;
			sd_s8  <= sd_c8;
			tn_s8  <= tn_c8;
			td_s8  <= td_s7;
			smode_s9 <= param_mode(sn_s8, sd_s8, eps_w);
			tmode_s9 <= param_mode(tn_s8, td_s8, eps_w);
			sn_s9  <= sn_s8;
			sd_s9  <= sd_s8;
			tn_s9  <= tn_s8;
			td_s9  <= td_s8;
			px_s26 <= px_c;
			py_s26 <= py_c;
			sqd_q  <= sqd_c;
		end
	end

	assign result.valid            = vld_q[LAT-1];
	assign result.squared_distance = sqd_q;

endmodule

>>> sv/ssd_chk.sv
`timescale 1ns / 1ps

module ssd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_valid,
	input logic                          pair_ready,
	input logic                          dist_valid,
	input logic                          dist_ready,
	input logic [ssd_pkg::OUT_WIDTH-1:0] dist_data,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// A stalled result stays offered.
	a_dist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && !dist_ready |=> dist_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result keeps its value.
	a_dist_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && !dist_ready |=> $stable(dist_data))
		else $error("result data changed while stalled");

	// A stalled output freezes the pipeline, so no new pair is taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && !dist_ready |-> !pair_ready)
		else $error("pair taken while output stalled");

	// With the output free the pipeline always advances.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!dist_valid |-> pair_ready && cfg_ready)
		else $error("block not ready with empty output");

	logic unused_pv;
	assign unused_pv = pair_valid | cfg_valid;

endmodule

bind segment_segment_sq_distance ssd_chk u_ssd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pair_valid (pair.valid),
	.pair_ready (pair.ready),
	.dist_valid (result.valid),
	.dist_ready (result.ready),
	.dist_data  (result.squared_distance),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);
